FILE: design/ftwa_pkg.sv
// Shared types and constants for the flow table with aging.
package ftwa_pkg;

  localparam logic [31:0] KEEPALIVE_RESET = 32'd30000;
  localparam int          COUNT_W         = 7;

  typedef enum logic [1:0] {
    OUT_MATCH  = 2'd0,
    OUT_INSERT = 2'd1,
    OUT_FULL   = 2'd2,
    OUT_SWEEP  = 2'd3
  } outcome_t;

  typedef enum logic {
    OP_TOUCH = 1'b0,
    OP_SWEEP = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  // Query token that walks the cell row; also used as insert write data.
  typedef struct packed {
    opcode_t     op;
    logic [63:0] addrs;   // {src_addr, dst_addr}
    logic [31:0] ports;   // {src_port, dst_port}
    logic [31:0] now_ms;
  } token_t;

  // Lookup status gathered along the row.
  typedef struct packed {
    logic hit;
    logic free;
  } flag_t;

endpackage

FILE: design/flow_table_with_aging.sv
// Flow table with idle aging: a row of FLOWS slot cells walked by one query token per item.
// A touch or sweep reaches the output in these steps: the accepting edge loads the first
// slot cell and the query token moves one cell per cycle, the control sees it at the row
// end and enters its finish state, and a commit there writes an inserted flow, updates the
// active count and loads the result. The input is ready again in the cycle after commit.
// A touch matches a flow in either direction and refreshes its timestamp, otherwise it
// takes the lowest free slot or reports the table full; a sweep drops every flow idle
// longer than keepalive_ms (elapsed time modulo 2^32). The next item is taken once the
// previous one has committed, even while its result still waits on the output; commit
// waits only if an older result is still held there. The user sees to it that keepalive_ms
// is written through keepalive_we only while the block is idle; the block does not enforce it.
module flow_table_with_aging #(
  parameter int FLOWS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         keepalive_we,
  input  logic [31:0]  keepalive_ms,
  input  logic         s_tvalid,
  output logic         s_tready,
  // src_addr[31:0], dst_addr[63:32], src_port[79:64], dst_port[95:80], now_ms[127:96]
  input  logic [127:0] s_tdata,
  // opcode[0]
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // flow_count[6:0], removed_count[13:7], zero[15:14]
  output logic [15:0]  m_tdata,
  // outcome[1:0]
  output logic [1:0]   m_tuser
);

  localparam int IDX_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;
  localparam int CNT_W = $clog2(FLOWS + 1);

  ftwa_pkg::state_t   state;
  ftwa_pkg::state_t   state_next;
  logic [31:0]        keepalive;
  logic [CNT_W-1:0]   active;
  logic [CNT_W-1:0]   active_next;

  logic               out_valid;
  ftwa_pkg::outcome_t out_outcome;
  logic [CNT_W-1:0]   out_count;
  logic [CNT_W-1:0]   out_removed;

  logic               accept;
  logic               commit;
  logic               wr_en;
  ftwa_pkg::outcome_t outcome;
  ftwa_pkg::token_t   head_tok;

  logic               vld      [0:FLOWS];
  ftwa_pkg::token_t   tok      [0:FLOWS];
  ftwa_pkg::flag_t    flag     [0:FLOWS];
  logic [IDX_W-1:0]   free_idx [0:FLOWS];
  logic [CNT_W-1:0]   removed  [0:FLOWS];

  assign accept = s_tvalid && s_tready;

  assign head_tok.op     = ftwa_pkg::opcode_t'(s_tuser[0]);
  assign head_tok.addrs  = {s_tdata[31:0], s_tdata[63:32]};
  assign head_tok.ports  = {s_tdata[79:64], s_tdata[95:80]};
  assign head_tok.now_ms = s_tdata[127:96];

  assign vld[0]      = accept;
  assign tok[0]      = head_tok;
  assign flag[0]     = '0;
  assign free_idx[0] = '0;
  assign removed[0]  = '0;

  for (genvar i = 0; i < FLOWS; i++) begin : g_cell
    ftwa_cell #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .IDX   (IDX_W'(i))
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .keepalive_ms (keepalive),
      .in_vld       (vld[i]),
      .in_tok       (tok[i]),
      .in_flag      (flag[i]),
      .in_free_idx  (free_idx[i]),
      .in_removed   (removed[i]),
      .wr_en        (wr_en),
      .wr_idx       (free_idx[FLOWS]),
      .wr_tok       (tok[FLOWS]),
      .out_vld      (vld[i+1]),
      .out_tok      (tok[i+1]),
      .out_flag     (flag[i+1]),
      .out_free_idx (free_idx[i+1]),
      .out_removed  (removed[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keepalive <= ftwa_pkg::KEEPALIVE_RESET;
    end else if (keepalive_we) begin
      keepalive <= keepalive_ms;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ftwa_pkg::ST_IDLE:   if (accept) state_next = ftwa_pkg::ST_WALK;
      ftwa_pkg::ST_WALK:   if (vld[FLOWS]) state_next = ftwa_pkg::ST_FINISH;
      ftwa_pkg::ST_FINISH: if (!out_valid || m_tready) state_next = ftwa_pkg::ST_IDLE;
      default:             state_next = ftwa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    commit   = 1'b0;
    case (state)
      ftwa_pkg::ST_IDLE:   s_tready = 1'b1;
      ftwa_pkg::ST_WALK:   s_tready = 1'b0;
      ftwa_pkg::ST_FINISH: commit = !out_valid || m_tready;
      default:             s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftwa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Row end holds the finished token until commit.
  always_comb begin
    if (tok[FLOWS].op == ftwa_pkg::OP_SWEEP) begin
      outcome = ftwa_pkg::OUT_SWEEP;
    end else if (flag[FLOWS].hit) begin
      outcome = ftwa_pkg::OUT_MATCH;
    end else if (flag[FLOWS].free) begin
      outcome = ftwa_pkg::OUT_INSERT;
    end else begin
      outcome = ftwa_pkg::OUT_FULL;
    end
  end

  assign wr_en = commit && (outcome == ftwa_pkg::OUT_INSERT);

  always_comb begin
    active_next = active;
    case (outcome)
      ftwa_pkg::OUT_SWEEP:  active_next = active - removed[FLOWS];
      ftwa_pkg::OUT_INSERT: active_next = active + CNT_W'(1);
      default:              active_next = active;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (commit) begin
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_outcome <= outcome;
      out_count   <= active_next;
      out_removed <= (outcome == ftwa_pkg::OUT_SWEEP) ? removed[FLOWS] : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_outcome;
  assign m_tdata  = {2'b00, ftwa_pkg::COUNT_W'(out_removed),
                     ftwa_pkg::COUNT_W'(out_count)};

endmodule

FILE: design/ftwa_cell.sv
// One flow table slot plus the token stage that follows it.
module ftwa_cell #(
  parameter int               IDX_W = 6,
  parameter int               CNT_W = 7,
  parameter logic [IDX_W-1:0] IDX   = '0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         keepalive_ms,
  input  logic                in_vld,
  input  ftwa_pkg::token_t    in_tok,
  input  ftwa_pkg::flag_t     in_flag,
  input  logic [IDX_W-1:0]    in_free_idx,
  input  logic [CNT_W-1:0]    in_removed,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_idx,
  input  ftwa_pkg::token_t    wr_tok,
  output logic                out_vld,
  output ftwa_pkg::token_t    out_tok,
  output ftwa_pkg::flag_t     out_flag,
  output logic [IDX_W-1:0]    out_free_idx,
  output logic [CNT_W-1:0]    out_removed
);

  logic        valid;
  logic [63:0] addrs;
  logic [31:0] ports;
  logic [31:0] last_seen;

  logic [63:0] rev_addrs;
  logic [31:0] rev_ports;
  logic [31:0] elapsed;
  logic        is_touch;
  logic        hit_here;
  logic        expired;
  logic        free_here;
  logic        wr_here;

  assign rev_addrs = {in_tok.addrs[31:0], in_tok.addrs[63:32]};
  assign rev_ports = {in_tok.ports[15:0], in_tok.ports[31:16]};
  assign elapsed   = in_tok.now_ms - last_seen;
  assign is_touch  = (in_tok.op == ftwa_pkg::OP_TOUCH);
  assign hit_here  = valid && is_touch && !in_flag.hit &&
                     (((addrs == in_tok.addrs) && (ports == in_tok.ports)) ||
                      ((addrs == rev_addrs) && (ports == rev_ports)));
  assign expired   = valid && !is_touch && (elapsed > keepalive_ms);
  assign free_here = !valid && is_touch && !in_flag.free;
  assign wr_here   = wr_en && (wr_idx == IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_here) begin
      valid <= 1'b1;
    end else if (in_vld && expired) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      addrs     <= wr_tok.addrs;
      ports     <= wr_tok.ports;
      last_seen <= wr_tok.now_ms;
    end else if (in_vld && hit_here) begin
      last_seen <= in_tok.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  // Payload holds once the token has passed, so the row end stays readable.
  always_ff @(posedge clk) begin
    if (in_vld) begin
      out_tok       <= in_tok;
      out_flag.hit  <= in_flag.hit | hit_here;
      out_flag.free <= in_flag.free | free_here;
      out_free_idx  <= free_here ? IDX : in_free_idx;
      out_removed   <= in_removed + CNT_W'(expired);
    end
  end

endmodule

FILE: design/ftwa_chk.sv
// Port-level checks for the flow table with aging, bound to the top level.
module ftwa_chk #(
  parameter int FLOWS = 64
) (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [15:0]  m_tdata,
  input logic [1:0]   m_tuser
);

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again while a query walks the row");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (FLOWS > 127) || (int'(m_tdata[6:0]) <= FLOWS))
    else $error("flow count above table size");

  a_touch_removes_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ftwa_pkg::OUT_SWEEP) |-> (m_tdata[13:7] == 7'd0))
    else $error("touch result reports removed entries");

endmodule

bind flow_table_with_aging ftwa_chk #(.FLOWS(FLOWS)) u_ftwa_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
